@@ rtl/tccc_pkg.sv @@
// tccc_pkg: shared types, codes and constants of the text console cursor control block
// used by tccc_ctrl, tccc_dp and the top level text_console_cursor_control
`default_nettype none

package tccc_pkg;

    // default screen store limits
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 128;

    // field widths of the stream items
    localparam int CP_W       = 21;
    localparam int NEW_COL_W  = 8;
    localparam int NEW_ROW_W  = 7;
    localparam int CELL_COL_W = 8;
    localparam int CELL_ROW_W = 7;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COLS_REG_W = 9;
    localparam int ROWS_REG_W = 8;
    localparam int RST_COLUMNS = 80;
    localparam int RST_ROWS    = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE  = 2'd0,
        REG_COLUMNS = 2'd1,
        REG_ROWS    = 2'd2
    } reg_idx_t;

    // character codes
    localparam logic [CP_W-1:0] CODE_TAB   = 21'h09;
    localparam logic [CP_W-1:0] CODE_LF    = 21'h0A;
    localparam logic [CP_W-1:0] CODE_CR    = 21'h0D;
    localparam logic [CP_W-1:0] CODE_SPACE = 21'h20;

    localparam int TAB_STOP = 4;
    localparam int CNT_W    = $clog2(TAB_STOP + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_DRAW   = 2'd2
    } cmd_t;

    // what the latched item asks for
    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_LF    = 2'd1,
        KIND_PRINT = 2'd2
    } kind_t;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_DECODE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_SCROLL = 3'd4,
        OP_DRAW   = 3'd5
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  pending;
        logic  row_on_screen;
        logic  lf_scroll;
        logic  wrap_scroll;
        logic  count_one;
        logic  count_zero;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/text_console_cursor_control.sv @@
// text_console_cursor_control: top level of the character-cell cursor engine
// instantiates tccc_ctrl and tccc_dp; types and codes from tccc_pkg
`default_nettype none

// Takes one code point or set-cursor request per input transfer and sends clear-row,
// scroll-up and draw-character commands, one per output transfer, with tlast on the
// final command of each input. The sequencer handles one input at a time: set cursor,
// carriage return and ignored codes only load and decode; a line feed adds a scroll
// step when it scrolls; a printable character adds a draw step, plus a clear step for
// a pending line clear and a scroll step for each scroll; a tab draws 4 - column mod 4
// spaces plus their clears and scrolls. Each command step waits while the output
// register holds a result not yet taken. Configuration takes effect at once and should
// be written only while no input is in progress.
module text_console_cursor_control #(
    parameter int MAX_COLUMNS = tccc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tccc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tccc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // code_point [20:0], new_column [28:21], new_row [35:29], zero [39:36]
    input  wire logic [tccc_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode [0]
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // cell_column [7:0], cell_row [14:8], glyph_code [35:15], zero [39:36]
    output logic [tccc_pkg::OUT_DATA_W-1:0]        m_tdata,
    // command [1:0]
    output logic [tccc_pkg::CMD_W-1:0]             m_tuser,
    output logic                                   m_tlast
);
    import tccc_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    tccc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    tccc_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    // the sequencer is busy right after taking an input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while the previous one is still in progress");

    // no characters of the previous input are left when a new one comes in
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> dp_stat.count_zero)
        else $error("character count not drained at input transfer");

    // a draw always lands on a row inside the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.op == OP_DRAW |-> dp_stat.row_on_screen)
        else $error("draw issued with cursor row beyond the screen");

    // a command is only issued into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == OP_DRAW || dp_cmd.op == OP_CLEAR || dp_cmd.op == OP_SCROLL)
            |-> (!m_tvalid || m_tready))
        else $error("command overwrote a result not yet transferred");

endmodule

`default_nettype wire

@@ rtl/tccc_dp.sv @@
// tccc_dp: datapath of the cursor engine: configuration, cursor state, item latch and
// result register; executes the operations issued by tccc_ctrl. depends on tccc_pkg
`default_nettype none

module tccc_dp #(
    parameter int MAX_COLUMNS = tccc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tccc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tccc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [tccc_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tccc_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [tccc_pkg::CMD_W-1:0]             m_tuser,
    output logic                                   m_tlast,
    input  wire tccc_pkg::dp_cmd_t                 cmd,
    output tccc_pkg::dp_stat_t                     stat
);
    import tccc_pkg::*;

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CNTW = (CW + 1 > COLS_REG_W) ? CW + 1 : COLS_REG_W;
    localparam int RNW  = (RW + 1 > ROWS_REG_W) ? RW + 1 : ROWS_REG_W;
    localparam int NCW  = (CW > NEW_COL_W) ? CW : NEW_COL_W;
    localparam int NRW  = (RW > NEW_ROW_W) ? RW : NEW_ROW_W;
    localparam int RST_COLS_EFF = (RST_COLUMNS > MAX_COLUMNS) ? MAX_COLUMNS : RST_COLUMNS;
    localparam int RST_ROWS_EFF = (RST_ROWS > MAX_ROWS) ? MAX_ROWS : RST_ROWS;

    // configuration, kept as effective limits
    logic            enable_reg;
    logic [CNTW-1:0] cols_eff_reg;
    logic [RNW-1:0]  rows_eff_reg;
    logic [CNTW-1:0] cols_in;
    logic [RNW-1:0]  rows_in;

    // cursor state
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // latched item
    logic                 mode_reg;
    logic [CP_W-1:0]      code_reg;
    logic [NEW_COL_W-1:0] new_col_reg;
    logic [NEW_ROW_W-1:0] new_row_reg;
    logic [CP_W-1:0]      glyph_reg, glyph_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    cmd_t                  m_cmd_reg, m_cmd_next;
    logic [CELL_COL_W-1:0] m_col_reg, m_col_next;
    logic [CELL_ROW_W-1:0] m_row_reg, m_row_next;
    logic [CP_W-1:0]       m_glyph_reg, m_glyph_next;
    logic                  m_last_reg, m_last_next;

    logic [CNTW-1:0] col_inc;
    logic [RNW-1:0]  row_inc;
    logic [RW-1:0]   row_bottom;
    logic            wrap;
    logic            out_free;
    logic            emit;
    kind_t           kind;
    logic [CW-1:0]   set_col;
    logic [RW-1:0]   set_row;

    always_comb begin
        cols_in = CNTW'(cfg_wdata[COLS_REG_W-1:0]);
        if (cols_in == '0) begin
            cols_in = CNTW'(1);
        end else if (cols_in > CNTW'(MAX_COLUMNS)) begin
            cols_in = CNTW'(MAX_COLUMNS);
        end
        rows_in = RNW'(cfg_wdata[ROWS_REG_W-1:0]);
        if (rows_in == '0) begin
            rows_in = RNW'(1);
        end else if (rows_in > RNW'(MAX_ROWS)) begin
            rows_in = RNW'(MAX_ROWS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            cols_eff_reg <= CNTW'(RST_COLS_EFF);
            rows_eff_reg <= RNW'(RST_ROWS_EFF);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENABLE:  enable_reg   <= cfg_wdata[0];
                REG_COLUMNS: cols_eff_reg <= cols_in;
                REG_ROWS:    rows_eff_reg <= rows_in;
                default: ;
            endcase
        end
    end

    assign col_inc    = CNTW'(col_reg) + CNTW'(1);
    assign row_inc    = RNW'(row_reg) + RNW'(1);
    assign row_bottom = RW'(rows_eff_reg - RNW'(1));
    assign wrap       = col_inc >= cols_eff_reg;
    assign out_free   = !m_valid_reg || m_tready;

    assign set_col = (NCW'(new_col_reg) > NCW'(MAX_COLUMNS - 1)) ? CW'(MAX_COLUMNS - 1)
                                                                 : CW'(new_col_reg);
    assign set_row = (NRW'(new_row_reg) > NRW'(MAX_ROWS - 1)) ? RW'(MAX_ROWS - 1)
                                                              : RW'(new_row_reg);

    always_comb begin
        if (!enable_reg || mode_reg) begin
            kind = KIND_NOP;
        end else if (code_reg == CODE_LF) begin
            kind = KIND_LF;
        end else if (code_reg == CODE_TAB || code_reg >= CODE_SPACE) begin
            kind = KIND_PRINT;
        end else begin
            kind = KIND_NOP;
        end
    end

    always_comb begin
        stat.kind          = kind;
        stat.pending       = pend_reg;
        stat.row_on_screen = RNW'(row_reg) < rows_eff_reg;
        stat.lf_scroll     = row_inc >= rows_eff_reg;
        stat.wrap_scroll   = wrap && (row_inc >= rows_eff_reg);
        stat.count_one     = count_reg == CNT_W'(1);
        stat.count_zero    = count_reg == '0;
        stat.out_free      = out_free;
    end

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        pend_next    = pend_reg;
        count_next   = count_reg;
        glyph_next   = glyph_reg;
        emit         = 1'b0;
        m_cmd_next   = m_cmd_reg;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        m_glyph_next = m_glyph_reg;
        m_last_next  = m_last_reg;
        case (cmd.op)
            OP_DECODE: begin
                count_next = '0;
                if (enable_reg) begin
                    if (mode_reg) begin
                        col_next = set_col;
                        row_next = set_row;
                    end else if (code_reg == CODE_CR) begin
                        col_next  = '0;
                        pend_next = 1'b1;
                    end else if (kind == KIND_LF) begin
                        col_next  = '0;
                        pend_next = 1'b0;
                        // on scroll the row is set by the scroll step
                        if (row_inc < rows_eff_reg) begin
                            row_next = RW'(row_inc);
                        end
                    end else if (kind == KIND_PRINT) begin
                        pend_next = 1'b0;
                        if (code_reg == CODE_TAB) begin
                            count_next = CNT_W'(TAB_STOP) - CNT_W'(col_reg[1:0]);
                            glyph_next = CODE_SPACE;
                        end else begin
                            count_next = CNT_W'(1);
                            glyph_next = code_reg;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                emit         = 1'b1;
                m_cmd_next   = CMD_CLEAR;
                m_col_next   = '0;
                m_row_next   = CELL_ROW_W'(row_reg);
                m_glyph_next = '0;
            end
            OP_SCROLL: begin
                emit         = 1'b1;
                m_cmd_next   = CMD_SCROLL;
                m_col_next   = '0;
                m_row_next   = '0;
                m_glyph_next = '0;
                row_next     = row_bottom;
                col_next     = '0;
            end
            OP_DRAW: begin
                emit         = 1'b1;
                m_cmd_next   = CMD_DRAW;
                m_col_next   = CELL_COL_W'(col_reg);
                m_row_next   = CELL_ROW_W'(row_reg);
                m_glyph_next = glyph_reg;
                count_next   = count_reg - CNT_W'(1);
                if (wrap) begin
                    col_next = '0;
                    if (row_inc < rows_eff_reg) begin
                        row_next = RW'(row_inc);
                    end
                end else begin
                    col_next = CW'(col_inc);
                end
            end
            default: ;
        endcase
        if (emit) begin
            m_last_next = cmd.last;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            code_reg    <= s_tdata[CP_W-1:0];
            new_col_reg <= s_tdata[CP_W +: NEW_COL_W];
            new_row_reg <= s_tdata[CP_W + NEW_COL_W +: NEW_ROW_W];
            mode_reg    <= s_tuser;
        end
        glyph_reg   <= glyph_next;
        m_cmd_reg   <= m_cmd_next;
        m_col_reg   <= m_col_next;
        m_row_reg   <= m_row_next;
        m_glyph_reg <= m_glyph_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_cmd_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(OUT_DATA_W - CELL_COL_W - CELL_ROW_W - CP_W){1'b0}},
                       m_glyph_reg, m_row_reg, m_col_reg};

endmodule

`default_nettype wire

@@ rtl/tccc_ctrl.sv @@
// tccc_ctrl: sequencer of the cursor engine; walks one item through decode, clear,
// scroll and draw steps and issues one datapath operation per step. depends on tccc_pkg
`default_nettype none

module tccc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tccc_pkg::dp_stat_t  stat,
    output tccc_pkg::dp_cmd_t        cmd
);
    import tccc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_DECODE     = 6'b000010,
        ST_CLEAR      = 6'b000100,
        ST_SCROLL_PRE = 6'b001000,
        ST_DRAW       = 6'b010000,
        ST_SCROLL_END = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.op = OP_DECODE;
                case (stat.kind)
                    KIND_LF:    state_next = stat.lf_scroll ? ST_SCROLL_END : ST_IDLE;
                    KIND_PRINT: begin
                        if (stat.pending && stat.row_on_screen) begin
                            state_next = ST_CLEAR;
                        end else if (!stat.row_on_screen) begin
                            state_next = ST_SCROLL_PRE;
                        end else begin
                            state_next = ST_DRAW;
                        end
                    end
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_CLEAR: begin
                if (stat.out_free) begin
                    cmd.op     = OP_CLEAR;
                    state_next = ST_DRAW;
                end
            end
            ST_SCROLL_PRE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_SCROLL;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (stat.out_free) begin
                    cmd.op   = OP_DRAW;
                    cmd.last = stat.count_one && !stat.wrap_scroll;
                    if (stat.wrap_scroll) begin
                        state_next = ST_SCROLL_END;
                    end else if (stat.count_one) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_SCROLL_END: begin
                // count already holds the characters still to draw
                if (stat.out_free) begin
                    cmd.op     = OP_SCROLL;
                    cmd.last   = stat.count_zero;
                    state_next = stat.count_zero ? ST_IDLE : ST_DRAW;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench: self-checking bench for text_console_cursor_control
// keeps its own cursor model; depends on tccc_pkg and the rtl top level only
`default_nettype none

module testbench;
    import tccc_pkg::*;

    typedef struct packed {
        logic            hold;     // sender waits for all due commands first
        logic            mode;
        logic [6:0]      new_row;
        logic [7:0]      new_col;
        logic [CP_W-1:0] code;
    } console_input_t;

    typedef struct packed {
        cmd_t            command;
        logic [7:0]      cell_col;
        logic [6:0]      cell_row;
        logic [CP_W-1:0] glyph;
        logic            last;
    } console_cmd_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [CMD_W-1:0]       m_tuser;
    logic                   m_tlast;

    text_console_cursor_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // console model: registers and cursor state
    bit          console_enabled = 1'b0;
    int unsigned screen_columns  = RST_COLUMNS;
    int unsigned screen_rows     = RST_ROWS;
    int unsigned cursor_col      = 0;
    int unsigned cursor_row      = 0;
    bit          line_clear_pending = 1'b0;

    console_input_t console_inputs[$];
    console_cmd_t   draw_cmds_due[$];
    console_cmd_t   staged_cmd;
    bit             staged_valid = 1'b0;

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    bit          item_taken        = 1'b0;
    int unsigned failures          = 0;
    int unsigned inputs_accepted   = 0;
    int unsigned cmds_checked      = 0;
    int unsigned settings_used     = 0;

    function automatic int unsigned live_columns();
        int unsigned c;
        c = (screen_columns == 0) ? 1 : screen_columns;
        return (c > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : c;
    endfunction

    function automatic int unsigned live_rows();
        int unsigned r;
        r = (screen_rows == 0) ? 1 : screen_rows;
        return (r > DEF_MAX_ROWS) ? DEF_MAX_ROWS : r;
    endfunction

    // one command is held back so the final one of an input can get its last flag
    function automatic void emit_command(cmd_t c, int unsigned col, int unsigned row,
                                         logic [CP_W-1:0] glyph);
        if (staged_valid)
            draw_cmds_due.push_back(staged_cmd);
        staged_cmd.command  = c;
        staged_cmd.cell_col = col[7:0];
        staged_cmd.cell_row = row[6:0];
        staged_cmd.glyph    = glyph;
        staged_cmd.last     = 1'b0;
        staged_valid        = 1'b1;
    endfunction

    function automatic void scroll_screen();
        emit_command(CMD_SCROLL, 0, 0, '0);
        cursor_row = live_rows() - 1;
        cursor_col = 0;
    endfunction

    function automatic void print_glyph(logic [CP_W-1:0] glyph);
        int unsigned nr;
        nr = live_rows();
        if (line_clear_pending) begin
            if (cursor_row < nr)
                emit_command(CMD_CLEAR, 0, cursor_row, '0);
            line_clear_pending = 1'b0;
        end
        if (cursor_row >= nr)
            scroll_screen();
        emit_command(CMD_DRAW, cursor_col, cursor_row, glyph);
        cursor_col++;
        if (cursor_col >= live_columns()) begin
            cursor_col = 0;
            cursor_row++;
            if (cursor_row >= nr)
                scroll_screen();
        end
    endfunction

    function automatic void predict_console(console_input_t it);
        int unsigned spaces;
        if (!console_enabled)
            return;
        if (it.mode) begin
            cursor_col = (32'(it.new_col) > DEF_MAX_COLUMNS - 1) ? DEF_MAX_COLUMNS - 1
                                                                 : 32'(it.new_col);
            cursor_row = (32'(it.new_row) > DEF_MAX_ROWS - 1) ? DEF_MAX_ROWS - 1
                                                              : 32'(it.new_row);
            return;
        end
        if (it.code == CODE_CR) begin
            cursor_col = 0;
            line_clear_pending = 1'b1;
        end else if (it.code == CODE_LF) begin
            cursor_col = 0;
            line_clear_pending = 1'b0;
            cursor_row++;
            if (cursor_row >= live_rows())
                scroll_screen();
        end else if (it.code == CODE_TAB) begin
            spaces = TAB_STOP - (cursor_col % TAB_STOP);
            for (int unsigned i = 0; i < spaces; i++)
                print_glyph(CODE_SPACE);
        end else if (it.code >= CODE_SPACE) begin
            print_glyph(it.code);
        end
        if (staged_valid) begin
            staged_cmd.last = 1'b1;
            draw_cmds_due.push_back(staged_cmd);
            staged_valid = 1'b0;
        end
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin : drive_proc
        console_input_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || item_taken) begin
                item_taken = 1'b0;
                if (console_inputs.size() != 0) begin
                    nxt = console_inputs[0];
                    if ($urandom_range(99) >= sender_idle_pct &&
                        !(nxt.hold && draw_cmds_due.size() != 0)) begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= {4'd0, nxt.new_row, nxt.new_col, nxt.code};
                        s_tuser  <= nxt.mode;
                    end else begin
                        s_tvalid <= 1'b0;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // monitor: both transfers sampled on the rising edge
    always @(posedge aclk) begin : monitor_proc
        console_cmd_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                item_taken = 1'b1;
                inputs_accepted++;
                predict_console(console_inputs.pop_front());
            end
            if (m_tvalid && m_tready) begin
                cmds_checked++;
                if (draw_cmds_due.size() == 0) begin
                    note_failure($sformatf("unexpected command %0d col %0d row %0d glyph %h last %0d",
                                           m_tuser, m_tdata[7:0], m_tdata[14:8],
                                           m_tdata[35:15], m_tlast));
                end else begin
                    want = draw_cmds_due.pop_front();
                    if (m_tuser !== want.command || m_tdata[7:0] !== want.cell_col ||
                        m_tdata[14:8] !== want.cell_row || m_tdata[35:15] !== want.glyph ||
                        m_tlast !== want.last)
                        note_failure($sformatf({"expected cmd %0d col %0d row %0d glyph %h last %0d,",
                                                " got cmd %0d col %0d row %0d glyph %h last %0d"},
                                               want.command, want.cell_col, want.cell_row,
                                               want.glyph, want.last, m_tuser, m_tdata[7:0],
                                               m_tdata[14:8], m_tdata[35:15], m_tlast));
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ENABLE:  console_enabled = val[0];
            REG_COLUMNS: screen_columns  = 32'(val[COLS_REG_W-1:0]);
            REG_ROWS:    screen_rows     = 32'(val[ROWS_REG_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // waits out due commands plus the sequencer time of a silent input
    task automatic wait_drained();
        while (console_inputs.size() != 0 || draw_cmds_due.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic push_char(logic [CP_W-1:0] code, bit hold = 1'b0);
        console_input_t it;
        it = '0;
        it.code = code;
        it.hold = hold;
        console_inputs.push_back(it);
    endtask

    task automatic push_cursor(int unsigned col, int unsigned row);
        console_input_t it;
        it = '0;
        it.mode    = 1'b1;
        it.new_col = col[7:0];
        it.new_row = row[6:0];
        console_inputs.push_back(it);
    endtask

    function automatic console_input_t random_input();
        console_input_t it;
        int unsigned pick;
        int unsigned lim;
        it = '0;
        it.hold = ($urandom_range(99) < 3);
        pick = $urandom_range(99);
        if (pick < 12) begin
            it.mode = 1'b1;
            // half the time land near the screen edges
            if ($urandom_range(1)) begin
                it.new_col = 8'($urandom_range(255));
                it.new_row = 7'($urandom_range(127));
            end else begin
                lim = (live_columns() + 1 > 255) ? 255 : live_columns() + 1;
                it.new_col = 8'($urandom_range(lim));
                lim = (live_rows() + 1 > 127) ? 127 : live_rows() + 1;
                it.new_row = 7'($urandom_range(lim));
            end
        end else if (pick < 50) begin
            it.code = CP_W'($urandom_range(126, 32));
        end else if (pick < 58) begin
            it.code = CODE_CR;
        end else if (pick < 66) begin
            it.code = CODE_LF;
        end else if (pick < 78) begin
            it.code = CODE_TAB;
        end else if (pick < 84) begin
            it.code = CP_W'($urandom_range(31));
        end else if (pick < 96) begin
            it.code = CP_W'($urandom_range(21'h1FFFFF));
        end else begin
            it.code = $urandom_range(1) ? 21'h1FFFFF : 21'h10FFFF;
        end
        return it;
    endfunction

    initial begin : stimulus
        int unsigned col_set [8];
        int unsigned row_set [8];
        col_set = '{80, 0, 1, 256, 511, 7, 40, 0};
        row_set = '{25, 0, 1, 128, 255, 3, 10, 0};
        col_set[7] = $urandom_range(511);
        row_set[7] = $urandom_range(255);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct   = 36;
        receiver_idle_pct = 66;

        // disabled after reset: everything ignored
        push_char(21'h51);
        push_cursor(5, 5);
        wait_drained();
        write_reg(REG_ENABLE, 9'd1);
        settings_used++;

        // reset screen size, extremes of the code point, each handled control code
        push_char(21'h41);
        push_char(21'h1FFFFF);
        push_char(21'h10FFFF);
        push_char(CODE_CR);
        push_char(21'h42);      // clears the line first
        push_char(CODE_LF);
        push_char(CODE_TAB);
        push_char(21'h78);
        push_char(CODE_TAB);    // from a column that is not a multiple of four
        push_char(21'h00);
        push_char(21'h1F);
        push_char(21'h7F);
        push_cursor(200, 3);    // column beyond the screen
        push_char(21'h43);
        push_char(CODE_CR);
        push_cursor(255, 127);  // row beyond the screen with a clear pending
        push_char(21'h45, 1'b1);
        push_cursor(79, 24);    // wrap at the bottom right corner scrolls
        push_char(21'h46);
        push_char(CODE_LF);     // line feed at the bottom scrolls

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            if (p < 3) begin
                sender_idle_pct   = 36;
                receiver_idle_pct = 66;
            end else if (p < 6) begin
                sender_idle_pct   = 66;
                receiver_idle_pct = 36;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (p == 5) begin
                write_reg(REG_ENABLE, 9'd0);
                for (int i = 0; i < 12; i++)
                    console_inputs.push_back(random_input());
                wait_drained();
                write_reg(REG_ENABLE, 9'd1);
            end
            write_reg(REG_COLUMNS, col_set[p][8:0]);
            write_reg(REG_ROWS, row_set[p][8:0]);
            settings_used++;
            for (int i = 0; i < 50; i++)
                console_inputs.push_back(random_input());
        end
        wait_drained();

        $display("run covered %0d accepted inputs, %0d commands checked, %0d screen settings",
                 inputs_accepted, cmds_checked, settings_used);
        if (failures == 0 && draw_cmds_due.size() == 0) begin
            $display("** text_console_cursor_control: PASSED **");
        end else begin
            $display("%0d failures, %0d commands still due", failures, draw_cmds_due.size());
            $display("** text_console_cursor_control: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("timeout with %0d inputs and %0d commands outstanding",
                 console_inputs.size(), draw_cmds_due.size());
        $display("** text_console_cursor_control: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
